[rtl/core/bol_pkg.sv]
package bol_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int OUT_CNT_W = 5;

    typedef enum logic [1:0] {
        FN_INS_FRONT = 2'd0,
        FN_INS_BACK  = 2'd1,
        FN_DELETE    = 2'd2,
        FN_DUMP      = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic start;   // new command word taken
        logic step;    // current dump word taken, load the next entry
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_last;  // word in the output register is the final one
    } dp_stat_t;

endpackage

[rtl/core/bol_ctrl.sv]
module bol_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  bol_pkg::dp_stat_t stat,
    output bol_pkg::ctl_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SEND = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   take_out;

    assign m_valid  = (state_reg == S_SEND);
    assign take_out = m_valid & m_ready;
    // next command may enter as soon as the final word of this one leaves
    assign s_ready  = (state_reg == S_IDLE) | (take_out & stat.out_last);

    assign cmd.start = s_valid & s_ready;
    assign cmd.step  = take_out & ~stat.out_last;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (cmd.start) state_next = S_SEND;
            end
            S_SEND: begin
                if (take_out & stat.out_last & ~cmd.start) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/bol_datapath.sv]
module bol_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  bol_pkg::ctl_cmd_t                  cmd,
    output bol_pkg::dp_stat_t                  stat,
    input  logic [1:0]                         s_func,
    input  logic signed [bol_pkg::DATA_W-1:0]  s_item_value,
    output logic [1:0]                         m_status,
    output logic signed [bol_pkg::DATA_W-1:0]  m_entry_value,
    output logic [bol_pkg::OUT_CNT_W-1:0]      m_entry_count,
    output logic                               m_last
);

    logic [bol_pkg::DATA_W-1:0] cells_reg [bol_pkg::CAPACITY];
    logic [bol_pkg::DATA_W-1:0] cells_next [bol_pkg::CAPACITY];
    logic [bol_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [bol_pkg::CNT_W-1:0]  idx_reg, idx_next;

    bol_pkg::status_t           status_reg, status_next;
    logic [bol_pkg::DATA_W-1:0] value_reg, value_next;
    logic                       last_reg, last_next;

    logic [bol_pkg::CAPACITY-1:0] match;
    logic [bol_pkg::CAPACITY-1:0] seen;
    logic full, empty, found;

    assign full  = (count_reg == bol_pkg::CNT_W'(bol_pkg::CAPACITY));
    assign empty = (count_reg == '0);
    assign found = seen[bol_pkg::CAPACITY-1];

    // parallel compare in every cell, prefix-OR marks the cells at and past the hit
    always_comb begin
        for (int i = 0; i < bol_pkg::CAPACITY; i++) begin
            match[i] = (cells_reg[i] == s_item_value)
                       && (bol_pkg::CNT_W'(i) < count_reg);
        end
        seen[0] = match[0];
        for (int i = 1; i < bol_pkg::CAPACITY; i++) begin
            seen[i] = seen[i-1] | match[i];
        end
    end

    always_comb begin
        cells_next  = cells_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        value_next  = value_reg;
        last_next   = last_reg;

        if (cmd.start) begin
            value_next  = '0;
            last_next   = 1'b1;
            status_next = bol_pkg::ST_OK;
            unique case (bol_pkg::func_t'(s_func))
                bol_pkg::FN_INS_FRONT: begin
                    if (full) begin
                        status_next = bol_pkg::ST_FULL;
                    end else begin
                        cells_next[0] = s_item_value;
                        for (int i = 1; i < bol_pkg::CAPACITY; i++) begin
                            cells_next[i] = cells_reg[i-1];
                        end
                        count_next = count_reg + 1'b1;
                    end
                end
                bol_pkg::FN_INS_BACK: begin
                    if (full) begin
                        status_next = bol_pkg::ST_FULL;
                    end else begin
                        cells_next[count_reg[bol_pkg::IDX_W-1:0]] = s_item_value;
                        count_next = count_reg + 1'b1;
                    end
                end
                bol_pkg::FN_DELETE: begin
                    if (empty) begin
                        status_next = bol_pkg::ST_EMPTY;
                    end else if (!found) begin
                        status_next = bol_pkg::ST_NOT_FOUND;
                    end else begin
                        for (int i = 0; i < bol_pkg::CAPACITY - 1; i++) begin
                            if (seen[i]) cells_next[i] = cells_reg[i+1];
                        end
                        count_next = count_reg - 1'b1;
                    end
                end
                default: begin
                    if (empty) begin
                        status_next = bol_pkg::ST_EMPTY;
                    end else begin
                        value_next = cells_reg[0];
                        last_next  = (count_reg == bol_pkg::CNT_W'(1));
                        idx_next   = bol_pkg::CNT_W'(1);
                    end
                end
            endcase
        end else if (cmd.step) begin
            value_next = cells_reg[idx_reg[bol_pkg::IDX_W-1:0]];
            last_next  = ((idx_reg + 1'b1) == count_reg);
            idx_next   = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            last_reg  <= 1'b1;
        end else begin
            count_reg <= count_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        cells_reg  <= cells_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        value_reg  <= value_next;
    end

    assign stat.out_last = last_reg;
    assign m_status      = status_reg;
    assign m_entry_value = value_reg;
    assign m_entry_count = bol_pkg::OUT_CNT_W'(count_reg);
    assign m_last        = last_reg;

endmodule

[rtl/core/bounded_ordered_list_unit.sv]
// Bounded ordered list: front/back insert, delete of first match, dump.
// Latency: result word is valid the cycle after the command word is taken.
// Throughput: insert/delete one command per cycle while the result side takes
// every word; a dump holds the input until its final entry word is taken (one read port).
// Reset (aresetn low, synchronous): list emptied, no result pending.
module bounded_ordered_list_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_func,
    input  logic signed [bol_pkg::DATA_W-1:0]  s_item_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_status,
    output logic signed [bol_pkg::DATA_W-1:0]  m_entry_value,
    output logic [bol_pkg::OUT_CNT_W-1:0]      m_entry_count,
    output logic                               m_last
);

    bol_pkg::ctl_cmd_t cmd;
    bol_pkg::dp_stat_t stat;

    // control: accept/hold sequencing, dump stepping
    bol_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath: the cell row (parallel compare and shift), count, output word
    bol_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_func        (s_func),
        .s_item_value  (s_item_value),
        .m_status      (m_status),
        .m_entry_value (m_entry_value),
        .m_entry_count (m_entry_count),
        .m_last        (m_last)
    );

endmodule

[rtl/core/bol_checker.sv]
module bol_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic [1:0]                         s_func,
    input logic signed [bol_pkg::DATA_W-1:0]  s_item_value,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [1:0]                         m_status,
    input logic signed [bol_pkg::DATA_W-1:0]  m_entry_value,
    input logic [bol_pkg::OUT_CNT_W-1:0]      m_entry_count,
    input logic                               m_last
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_entry_value) && $stable(m_entry_count) && $stable(m_last))
        else $error("result word changed while stalled");

    a_resp_next: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("no result the cycle after a command");

    a_dump_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid && m_status == bol_pkg::ST_OK
            && $stable(m_entry_count))
        else $error("dump broken off");

    a_no_accept_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("command taken in the middle of a dump");

    a_full_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == bol_pkg::ST_FULL |->
            m_entry_count == bol_pkg::OUT_CNT_W'(bol_pkg::CAPACITY))
        else $error("full status with a short count");

endmodule

bind bounded_ordered_list_unit bol_checker u_chk (.*);
